// ===== sv/fisc_pkg.sv =====
// ----------------------------------------------------------------------------
// fisc_pkg
// Types, constants and codes shared by the epipolar inlier scoring core.
// ----------------------------------------------------------------------------
package fisc_pkg;

    // chi-square limit 3.841 and score base 5.991, both Q16.16
    localparam logic [17:0] TH_Q16    = 18'd251724;
    localparam logic [18:0] SCORE_Q16 = 19'd392626;

    // default depth of the input and result queues
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PAIR_ONE   = 3'd0,
        REG_PAIR_TWO   = 3'd1,
        REG_PAIR_THREE = 3'd2,
        REG_PAIR_FOUR  = 3'd3,
        REG_CORNER     = 3'd4,
        REG_INV_SIGMA  = 3'd5
    } reg_index_t;

    // engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_EMIT
    } eng_state_t;

    // F entries in row-major order (signed Q2.30) and inverse sigma squared
    typedef struct packed {
        logic [8:0][31:0] f;
        logic [23:0]      sig;
    } coef_t;

    // one correspondence
    typedef struct packed {
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic [15:0] second_x;
        logic [15:0] second_y;
        logic        last_match;
    } item_t;

    // one result
    typedef struct packed {
        logic        inlier;
        logic        forward_pass;
        logic        backward_pass;
        logic [31:0] running_score;
        logic        batch_end;
    } result_t;

endpackage

// ===== sv/fisc_queue.sv =====
// ----------------------------------------------------------------------------
// fisc_queue
// Small synchronous FIFO used on the input and result sides of the core.
// ----------------------------------------------------------------------------
module fisc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/fisc_engine.sv =====
// ----------------------------------------------------------------------------
// fisc_engine
// Back end: shared 33x33 multiply-accumulate sequencer and restoring divider
// that score one correspondence in both directions.
// ----------------------------------------------------------------------------
module fisc_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  fisc_pkg::coef_t coef,
    input  logic            in_empty,
    input  fisc_pkg::item_t in_item,
    output logic            in_pop,
    input  logic            out_full,
    output logic            out_push,
    output fisc_pkg::result_t out_res
);
    import fisc_pkg::*;

    localparam logic [4:0] STEP_LAST = 5'd20;
    localparam logic [4:0] BIT_TOP   = 5'd18;

    eng_state_t state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [4:0]  bit_reg, bit_next;
    logic        dir_reg, dir_next;
    logic        fwd_reg, fwd_next;
    logic        bwd_reg, bwd_next;
    logic [31:0] score_reg, score_next;
    item_t       item_reg, item_next;

    logic signed [127:0] acc_reg, acc_next;
    logic signed [31:0]  la_reg, la_next;
    logic signed [31:0]  lb_reg, lb_next;
    logic signed [31:0]  lc_reg, lc_next;
    logic [61:0]         d_reg, d_next;
    logic [48:0]         mag_reg, mag_next;
    logic [96:0]         mag2_reg, mag2_next;
    logic [120:0]        rem_reg, rem_next;
    logic [17:0]         q_reg, q_next;

    // operand selection
    logic [15:0]         px, py, qx, qy;
    logic [1:0]          k_sel, j_sel;
    logic [3:0]          f_idx;
    logic [31:0]         f_val;
    logic signed [32:0]  op_a, op_b;
    logic                clr;
    logic [6:0]          sh;
    logic signed [65:0]  prod;
    logic signed [127:0] prod_ext;
    logic signed [127:0] acc_base;
    logic signed [127:0] acc_shr;
    logic signed [127:0] acc_abs;

    // divider and direction finish
    logic [120:0] div_t;
    logic         div_ge;
    logic         dir_done;
    logic         dir_pass;
    logic [17:0]  dir_chi;
    logic [32:0]  score_sum;

    assign px = dir_reg ? item_reg.second_x : item_reg.first_x;
    assign py = dir_reg ? item_reg.second_y : item_reg.first_y;
    assign qx = dir_reg ? item_reg.first_x  : item_reg.second_x;
    assign qy = dir_reg ? item_reg.first_y  : item_reg.second_y;

    // line coefficient term: row k of F, or column k for the backward line
    always_comb
    begin
        k_sel = 2'd0;
        j_sel = 2'd0;
        case (step_reg)
            5'd1:    begin k_sel = 2'd0; j_sel = 2'd1; end
            5'd2:    begin k_sel = 2'd0; j_sel = 2'd2; end
            5'd3:    begin k_sel = 2'd1; j_sel = 2'd0; end
            5'd4:    begin k_sel = 2'd1; j_sel = 2'd1; end
            5'd5:    begin k_sel = 2'd1; j_sel = 2'd2; end
            5'd6:    begin k_sel = 2'd2; j_sel = 2'd0; end
            5'd7:    begin k_sel = 2'd2; j_sel = 2'd1; end
            5'd8:    begin k_sel = 2'd2; j_sel = 2'd2; end
            default: begin k_sel = 2'd0; j_sel = 2'd0; end
        endcase
        f_idx = dir_reg ? (4'd3 * 4'(j_sel) + 4'(k_sel))
                        : (4'd3 * 4'(k_sel) + 4'(j_sel));
    end

    assign f_val = coef.f[f_idx];

    // multiply-accumulate operand schedule
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        clr  = 1'b0;
        sh   = 7'd0;
        case (step_reg)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8:
            begin
                op_a = {f_val[31], f_val};
                op_b = (j_sel == 2'd0) ? {17'd0, px} :
                       (j_sel == 2'd1) ? {17'd0, py} : 33'sd16;
                clr  = (j_sel == 2'd0);
            end
            5'd9:  begin op_a = {la_reg[31], la_reg}; op_b = {la_reg[31], la_reg}; clr = 1'b1; end
            5'd10: begin op_a = {lb_reg[31], lb_reg}; op_b = {lb_reg[31], lb_reg}; end
            5'd11: begin op_a = {la_reg[31], la_reg}; op_b = {17'd0, qx}; clr = 1'b1; end
            5'd12: begin op_a = {lb_reg[31], lb_reg}; op_b = {17'd0, qy}; end
            5'd13: begin op_a = {lc_reg[31], lc_reg}; op_b = 33'sd16; end
            5'd14:
            begin
                op_a = {1'b0, mag_reg[31:0]};
                op_b = {1'b0, mag_reg[31:0]};
                clr  = 1'b1;
            end
            5'd15:
            begin
                op_a = {1'b0, mag_reg[31:0]};
                op_b = {16'd0, mag_reg[48:32]};
                sh   = 7'd33;
            end
            5'd16:
            begin
                op_a = {16'd0, mag_reg[48:32]};
                op_b = {16'd0, mag_reg[48:32]};
                sh   = 7'd64;
            end
            5'd17:
            begin
                op_a = {1'b0, mag2_reg[31:0]};
                op_b = {9'd0, coef.sig};
                clr  = 1'b1;
            end
            5'd18:
            begin
                op_a = {1'b0, mag2_reg[63:32]};
                op_b = {9'd0, coef.sig};
                sh   = 7'd32;
            end
            5'd19:
            begin
                op_a = {1'b0, mag2_reg[95:64]};
                op_b = {9'd0, coef.sig};
                sh   = 7'd64;
            end
            5'd20:
            begin
                op_a = {32'd0, mag2_reg[96]};
                op_b = {9'd0, coef.sig};
                sh   = 7'd96;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // shared multiplier and accumulator
    assign prod     = op_a * op_b;
    assign prod_ext = {{62{prod[65]}}, prod};
    assign acc_base = clr ? '0 : acc_reg;
    assign acc_next = acc_base + (prod_ext <<< sh);
    assign acc_shr  = acc_next >>> 18;
    assign acc_abs  = acc_next[127] ? -acc_next : acc_next;

    // restoring division step against (d << 8) << bit
    assign div_t     = 121'({d_reg, 8'd0}) << bit_reg;
    assign div_ge    = (rem_reg >= div_t);
    assign score_sum = {1'b0, score_reg} + 33'({1'b0, SCORE_Q16} - {1'b0, dir_chi});

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        dir_next   = dir_reg;
        fwd_next   = fwd_reg;
        bwd_next   = bwd_reg;
        score_next = score_reg;
        item_next  = item_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        lc_next    = lc_reg;
        d_next     = d_reg;
        mag_next   = mag_reg;
        mag2_next  = mag2_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        dir_done   = 1'b0;
        dir_pass   = 1'b0;
        dir_chi    = '0;
        in_pop     = 1'b0;
        out_push   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!in_empty && !out_full)
                begin
                    in_pop     = 1'b1;
                    item_next  = in_item;
                    dir_next   = 1'b0;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    5'd2:  la_next   = acc_shr[31:0];
                    5'd5:  lb_next   = acc_shr[31:0];
                    5'd8:  lc_next   = acc_shr[31:0];
                    5'd10: d_next    = acc_next[61:0];
                    5'd13: mag_next  = acc_abs[48:0];
                    5'd16: mag2_next = acc_next[96:0];
                    5'd20: rem_next  = acc_next[120:0];
                    default: ;
                endcase
                if (step_reg == STEP_LAST)
                begin
                    if (d_reg == '0)
                    begin
                        // zero line norm: direction fails
                        dir_done = 1'b1;
                    end
                    else
                    begin
                        bit_next   = BIT_TOP;
                        q_next     = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (bit_reg == BIT_TOP)
                begin
                    // quotient too large: fails
                    if (div_ge)
                    begin
                        dir_done = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                    end
                end
                else
                begin
                    if (div_ge)
                    begin
                        rem_next = rem_reg - div_t;
                    end
                    q_next = q_reg | (18'(div_ge) << bit_reg);
                    if (bit_reg == '0)
                    begin
                        dir_done = 1'b1;
                        dir_chi  = q_next;
                        dir_pass = (q_next <= TH_Q16);
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                out_push = 1'b1;
                if (item_reg.last_match)
                begin
                    score_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // direction finished: score and move on
        if (dir_done)
        begin
            if (dir_pass)
            begin
                score_next = score_sum[32] ? 32'hFFFF_FFFF : score_sum[31:0];
            end
            if (!dir_reg)
            begin
                fwd_next   = dir_pass;
                dir_next   = 1'b1;
                step_next  = '0;
                state_next = ST_MAC;
            end
            else
            begin
                bwd_next   = dir_pass;
                state_next = ST_EMIT;
            end
        end
    end

    assign out_res.inlier        = fwd_reg && bwd_reg;
    assign out_res.forward_pass  = fwd_reg;
    assign out_res.backward_pass = bwd_reg;
    assign out_res.running_score = score_reg;
    assign out_res.batch_end     = item_reg.last_match;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
            dir_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
            bwd_reg   <= 1'b0;
            score_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            dir_reg   <= dir_next;
            fwd_reg   <= fwd_next;
            bwd_reg   <= bwd_next;
            score_reg <= score_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (state_reg == ST_MAC)
        begin
            acc_reg <= acc_next;
        end
        la_reg   <= la_next;
        lb_reg   <= lb_next;
        lc_reg   <= lc_next;
        d_reg    <= d_next;
        mag_reg  <= mag_next;
        mag2_reg <= mag2_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

endmodule

// ===== sv/fundamental_inlier_scoring_core.sv =====
// ----------------------------------------------------------------------------
// fundamental_inlier_scoring_core
// Symmetric epipolar distance inlier test and running score for one F.
// ----------------------------------------------------------------------------
// Each correspondence is scored in both directions. Per direction the single
// shared 33x33 multiply-accumulate unit steps through line, norm, numerator,
// square and sigma scaling, then one to 19 steps of the restoring divider
// follow (none when the line norm is zero). The item is taken in the idle state
// and the result posted in the emit state. Input and result queues sit on both
// sides, so items may be pushed and results left waiting while the engine runs.
// Write configuration only while the core is idle; the score clears after an
// item flagged last_match is posted.
module fundamental_inlier_scoring_core #(
    parameter int QUEUE_DEPTH = fisc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] first_x,
    input  logic [15:0] first_y,
    input  logic [15:0] second_x,
    input  logic [15:0] second_y,
    input  logic        last_match,
    output logic        empty,
    input  logic        pop,
    output logic        inlier,
    output logic        forward_pass,
    output logic        backward_pass,
    output logic [31:0] running_score,
    output logic        batch_end
);
    import fisc_pkg::*;

    coef_t   coef_reg;
    item_t   in_wdata;
    item_t   in_rdata;
    logic    in_empty;
    logic    in_pop;
    result_t out_wdata;
    result_t out_rdata;
    logic    out_full;
    logic    out_push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.f   <= '0;
            coef_reg.sig <= 24'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAIR_ONE:
                begin
                    coef_reg.f[0] <= cfg_data[63:32];
                    coef_reg.f[1] <= cfg_data[31:0];
                end
                REG_PAIR_TWO:
                begin
                    coef_reg.f[2] <= cfg_data[63:32];
                    coef_reg.f[3] <= cfg_data[31:0];
                end
                REG_PAIR_THREE:
                begin
                    coef_reg.f[4] <= cfg_data[63:32];
                    coef_reg.f[5] <= cfg_data[31:0];
                end
                REG_PAIR_FOUR:
                begin
                    coef_reg.f[6] <= cfg_data[63:32];
                    coef_reg.f[7] <= cfg_data[31:0];
                end
                REG_CORNER:    coef_reg.f[8] <= cfg_data[31:0];
                REG_INV_SIGMA: coef_reg.sig  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign in_wdata.first_x    = first_x;
    assign in_wdata.first_y    = first_y;
    assign in_wdata.second_x   = second_x;
    assign in_wdata.second_y   = second_y;
    assign in_wdata.last_match = last_match;

    // front: input queue
    fisc_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_wdata),
        .full  (full),
        .pop   (in_pop),
        .rdata (in_rdata),
        .empty (in_empty)
    );

    // back: scoring engine
    fisc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .in_empty (in_empty),
        .in_item  (in_rdata),
        .in_pop   (in_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_res  (out_wdata)
    );

    // result queue
    fisc_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign inlier        = out_rdata.inlier;
    assign forward_pass  = out_rdata.forward_pass;
    assign backward_pass = out_rdata.backward_pass;
    assign running_score = out_rdata.running_score;
    assign batch_end     = out_rdata.batch_end;

endmodule
